// ===== rtl/ipsc_pkg.sv =====
// ipsc_pkg: shared types and constants for the in-order pipeline stage controller
// no dependencies; used by ipsc_ctrl, ipsc_datapath, the top level and the checker
package ipsc_pkg;

	localparam int DataInW  = 96;
	localparam int UserInW  = 3;
	localparam int DataOutW = 96;

	// command codes carried on s_tuser
	localparam logic [2:0] CMD_TICK        = 3'd0;
	localparam logic [2:0] CMD_FLUSH_ALL   = 3'd1;
	localparam logic [2:0] CMD_FLUSH_FRONT = 3'd2;
	localparam logic [2:0] CMD_SET_PC      = 3'd3;
	localparam logic [2:0] CMD_LOAD_STALL  = 3'd4;

	localparam logic [15:0] NOP_WORD  = 16'h0009;
	localparam logic [31:0] ADDR_MASK = ~32'h0000_0003;

	// stage_mask bit positions
	localparam int S_IF = 0;
	localparam int S_ID = 1;
	localparam int S_EX = 2;
	localparam int S_MA = 3;
	localparam int S_WB = 4;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} fsm_t;

	typedef struct packed {
		logic        branch_op;
		logic        mem_op;
		logic [3:0]  lat_ma;
		logic [3:0]  lat_ex;
		logic [15:0] fetch_word;
		logic [31:0] lock_addr;
		logic        lock_is_mine;
		logic        bus_locked;
		logic        drain;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  stage_mask;
		logic        release_lock;
		logic [31:0] fetch_pc;
		logic        fetched;
		logic        retire;
		logic [15:0] exec_word;
		logic [31:0] exec_pc;
		logic        exec_fire;
	} out_item_t;

	// contents carried from stage to stage
	typedef struct packed {
		logic [15:0] word;
		logic [31:0] pc;
		logic [3:0]  ex_lat;
		logic [3:0]  ma_lat;
		logic        mem;
		logic        br;
	} stage_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic commit;
	} ctrl_cmd_t;

endpackage

// ===== rtl/inorder_pipeline_stage_controller_unit.sv =====
// inorder_pipeline_stage_controller_unit: top level of the pipeline stage controller
// depends on ipsc_pkg, ipsc_ctrl, ipsc_datapath
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser: cmd; tdata: operands and fetched word
//  m_*      out  m_tvalid/m_tready   tdata: step result
//
// each word is first captured into the input register; then the stage advance rules are
// evaluated and the new state and result are committed together
// a new word is taken while the previous result still waits in the output register
// if the result is still held when the commit cycle comes, the commit waits for m_tready
// reset clears all stages, countdowns, the pc and the fetch stall count
module inorder_pipeline_stage_controller_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [31:0] value, [32] drain, [33] bus_locked, [34] lock_is_mine, [66:35] lock_addr,
	// [82:67] fetch_word, [86:83] lat_ex, [90:87] lat_ma, [91] mem_op, [92] branch_op
	input  logic [ipsc_pkg::DataInW-1:0]  s_tdata,
	// [2:0] cmd
	input  logic [ipsc_pkg::UserInW-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [0] exec_fire, [32:1] exec_pc, [48:33] exec_word, [49] retire, [50] fetched,
	// [82:51] fetch_pc, [83] release_lock, [88:84] stage_mask
	output logic [ipsc_pkg::DataOutW-1:0] m_tdata
);

	ipsc_pkg::ctrl_cmd_t cmd;

	ipsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ipsc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_user  (s_tuser),
		.in_data  (s_tdata),
		.out_data (m_tdata)
	);

endmodule

// ===== rtl/ipsc_ctrl.sv =====
// ipsc_ctrl: handshake state machine, sequences input capture and state commit
// depends on ipsc_pkg
module ipsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output ipsc_pkg::ctrl_cmd_t  cmd
);

	ipsc_pkg::fsm_t state_q, state_d;
	logic           out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ipsc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		s_tready    = 1'b0;
		if (out_valid_q && m_tready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			ipsc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ipsc_pkg::ST_RUN;
				end
			end
			ipsc_pkg::ST_RUN: begin
				// commit only once the output register is free or being emptied
				if (!out_valid_q || m_tready) begin
					cmd.commit  = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ipsc_pkg::ST_IDLE;
				end
			end
			default: state_d = ipsc_pkg::ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== rtl/ipsc_datapath.sv =====
// ipsc_datapath: input register, stage occupancy state, advance rules, output register
// depends on ipsc_pkg; driven by ipsc_ctrl
module ipsc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ipsc_pkg::ctrl_cmd_t           cmd,
	input  logic [ipsc_pkg::UserInW-1:0]  in_user,
	input  logic [ipsc_pkg::DataInW-1:0]  in_data,
	output logic [ipsc_pkg::DataOutW-1:0] out_data
);

	localparam int InBits  = $bits(ipsc_pkg::in_item_t);
	localparam int OutBits = $bits(ipsc_pkg::out_item_t);

	ipsc_pkg::in_item_t  item_q;
	logic [2:0]          op_q;
	ipsc_pkg::out_item_t res_q, res_d;

	ipsc_pkg::stage_t if_q, id_q, ex_q, ma_q;
	ipsc_pkg::stage_t if_d, id_d, ex_d, ma_d;
	logic [4:0]       valid_q, valid_d;
	logic [3:0]       cd_ex_q, cd_ma_q, cd_ex_d, cd_ma_d;
	logic [31:0]      pc_q, pc_d, stall_q, stall_d;

	logic rel, locked_eff, touches, retire, fire, mv_id, mv_if, fetch;
	logic [3:0] cd_ma_dec, cd_ex_dec;
	logic [31:0] stall_dec;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			item_q <= ipsc_pkg::in_item_t'(in_data[InBits-1:0]);
			op_q   <= in_user;
		end
		if (cmd.commit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			if_q    <= '0;
			id_q    <= '0;
			ex_q    <= '0;
			ma_q    <= '0;
			valid_q <= '0;
			cd_ex_q <= '0;
			cd_ma_q <= '0;
			pc_q    <= '0;
			stall_q <= '0;
		end else if (cmd.commit) begin
			if_q    <= if_d;
			id_q    <= id_d;
			ex_q    <= ex_d;
			ma_q    <= ma_d;
			valid_q <= valid_d;
			cd_ex_q <= cd_ex_d;
			cd_ma_q <= cd_ma_d;
			pc_q    <= pc_d;
			stall_q <= stall_d;
		end
	end

	// tick rules, evaluated in stage order from writeback back to fetch
	always_comb begin
		rel        = item_q.bus_locked && item_q.lock_is_mine && (stall_q == '0) &&
		             ((cd_ma_q == '0) || !valid_q[ipsc_pkg::S_MA]);
		locked_eff = item_q.bus_locked && !rel;

		cd_ma_dec = (valid_q[ipsc_pkg::S_MA] && cd_ma_q != '0) ? cd_ma_q - 4'd1 : cd_ma_q;
		retire    = valid_q[ipsc_pkg::S_MA] && (cd_ma_dec == '0);

		cd_ex_dec = (valid_q[ipsc_pkg::S_EX] && cd_ex_q != '0) ? cd_ex_q - 4'd1 : cd_ex_q;
		touches   = valid_q[ipsc_pkg::S_EX] &&
		            (ex_q.mem || (ex_q.br && valid_q[ipsc_pkg::S_ID] && id_q.mem));
		fire      = valid_q[ipsc_pkg::S_EX] && (cd_ex_dec == '0) &&
		            (!valid_q[ipsc_pkg::S_MA] || retire) &&
		            (!locked_eff || item_q.lock_is_mine || !touches);

		stall_dec = (stall_q != '0) ? stall_q - 32'd1 : stall_q;

		mv_id = valid_q[ipsc_pkg::S_ID] && (stall_dec == '0) &&
		        (!valid_q[ipsc_pkg::S_EX] || fire);
		mv_if = (!valid_q[ipsc_pkg::S_ID] || mv_id) && valid_q[ipsc_pkg::S_IF] &&
		        (stall_dec == '0);
		fetch = (!valid_q[ipsc_pkg::S_IF] || mv_if) &&
		        (!locked_eff || item_q.lock_is_mine ||
		         ((pc_q & ipsc_pkg::ADDR_MASK) != item_q.lock_addr));
	end

	always_comb begin
		if_d    = if_q;
		id_d    = id_q;
		ex_d    = ex_q;
		ma_d    = ma_q;
		valid_d = valid_q;
		cd_ex_d = cd_ex_q;
		cd_ma_d = cd_ma_q;
		pc_d    = pc_q;
		stall_d = stall_q;
		res_d   = '0;

		unique case (op_q)
			ipsc_pkg::CMD_FLUSH_ALL: begin
				valid_d = '0;
				cd_ex_d = '0;
				cd_ma_d = '0;
			end
			ipsc_pkg::CMD_FLUSH_FRONT: begin
				valid_d[ipsc_pkg::S_IF] = 1'b0;
				valid_d[ipsc_pkg::S_ID] = 1'b0;
			end
			ipsc_pkg::CMD_SET_PC: begin
				pc_d = item_q.value;
			end
			ipsc_pkg::CMD_LOAD_STALL: begin
				stall_d = item_q.value;
			end
			ipsc_pkg::CMD_TICK: begin
				stall_d = stall_dec;
				cd_ma_d = cd_ma_dec;
				cd_ex_d = cd_ex_dec;
				valid_d[ipsc_pkg::S_WB] = retire;
				if (retire) begin
					valid_d[ipsc_pkg::S_MA] = 1'b0;
				end
				if (fire) begin
					ma_d                    = ex_q;
					cd_ma_d                 = ex_q.ma_lat;
					valid_d[ipsc_pkg::S_MA] = 1'b1;
					valid_d[ipsc_pkg::S_EX] = 1'b0;
				end
				if (mv_id) begin
					ex_d                    = id_q;
					cd_ex_d                 = id_q.ex_lat;
					valid_d[ipsc_pkg::S_EX] = 1'b1;
					valid_d[ipsc_pkg::S_ID] = 1'b0;
				end
				if (mv_if) begin
					id_d                    = if_q;
					valid_d[ipsc_pkg::S_ID] = 1'b1;
					valid_d[ipsc_pkg::S_IF] = 1'b0;
				end
				if (fetch) begin
					if_d.word   = item_q.drain ? ipsc_pkg::NOP_WORD : item_q.fetch_word;
					if_d.pc     = pc_q;
					if_d.ex_lat = item_q.lat_ex;
					if_d.ma_lat = item_q.lat_ma;
					if_d.mem    = item_q.mem_op;
					if_d.br     = item_q.branch_op;
					valid_d[ipsc_pkg::S_IF] = 1'b1;
					if (!item_q.drain) begin
						pc_d = pc_q + 32'd2;
					end
				end
				res_d.exec_fire    = fire;
				res_d.exec_pc      = fire ? ex_q.pc : '0;
				res_d.exec_word    = fire ? ex_q.word : '0;
				res_d.retire       = retire;
				res_d.fetched      = fetch;
				res_d.release_lock = rel;
			end
			default: begin
				// unknown commands leave the state alone
			end
		endcase
		res_d.fetch_pc   = pc_d;
		res_d.stage_mask = valid_d;
	end

	assign out_data = {{(ipsc_pkg::DataOutW - OutBits){1'b0}}, res_q};

endmodule

// ===== rtl/ipsc_checker.sv =====
// ipsc_checker: port-level checks on the pipeline stage controller
// depends on ipsc_pkg; bound to inorder_pipeline_stage_controller_unit
module ipsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ipsc_pkg::DataOutW-1:0] m_tdata
);

	// one word in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word accepted while one is in work");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// a fired instruction lands in memory stage
	a_fire_ma: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[84 + ipsc_pkg::S_MA])
		else $error("exec_fire without memory stage valid");

	a_fetch_if: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[50] |-> m_tdata[84 + ipsc_pkg::S_IF])
		else $error("fetched without fetch stage valid");

	a_retire_wb: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[49] |-> m_tdata[84 + ipsc_pkg::S_WB])
		else $error("retire without writeback valid");

endmodule

bind inorder_pipeline_stage_controller_unit ipsc_checker u_ipsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
